// ===== design/bcg_pkg.sv =====
`timescale 1ns / 1ps

package bcg_pkg;

  localparam int TICK_W  = 7;
  localparam int COUNT_W = 4;
  localparam int TIMER_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [TIMER_W-1:0] TIMER_MAX = 8'sh7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS    = 2'd0,
    CFG_SHORT_PRESS   = 2'd1,
    CFG_RELEASE_TMO   = 2'd2,
    CFG_MAX_CLICKS    = 2'd3
  } cfg_index_t;

  localparam logic [TICK_W-1:0]  LONG_PRESS_RST  = 7'd50;
  localparam logic [TICK_W-1:0]  SHORT_PRESS_RST = 7'd2;
  localparam logic [TICK_W-1:0]  RELEASE_TMO_RST = 7'd15;
  localparam logic [COUNT_W-1:0] MAX_CLICKS_RST  = 4'd4;

  typedef struct packed {
    logic [TICK_W-1:0]  long_press_ticks;
    logic [TICK_W-1:0]  short_press_ticks;
    logic [TICK_W-1:0]  release_timeout_ticks;
    logic [COUNT_W-1:0] max_clicks;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] click_result;
    logic               long_active;
    logic               result_written;
  } result_t;

endpackage

// ===== design/bcg_in_if.sv =====
`timescale 1ns / 1ps

interface bcg_in_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

// ===== design/bcg_out_if.sv =====
`timescale 1ns / 1ps

interface bcg_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcg_pkg::COUNT_W-1:0] click_result;
  logic                       long_active;
  logic                       result_written;

  modport source (output valid, output click_result, output long_active,
                  output result_written, input ready);
  modport sink (input valid, input click_result, input long_active,
                input result_written, output ready);
endinterface

// ===== design/button_click_gesture_detector.sv =====
`timescale 1ns / 1ps

// Button click / long-press gesture detector.
// button: one request per scan tick, carrying the button level (pressed).
// result: one request per input tick with the reported click count, the
//   long-press flag and a pulse marking a tick that wrote the result.
// Config: cfg_we/cfg_index/cfg_wdata write long press, short press,
//   release timeout and max click registers; write only while idle.
// Path: an accepted tick sits in the input register, and its result is
//   registered in the result register, from which it is taken.
// Throughput: one tick per cycle unless stalled; the gesture state update is
//   a single compare/increment step between the input and result registers.
// Stall: when the receiver holds ready low, the result register holds its
//   request, the input register fills, and button.ready drops until the
//   result is taken. Nothing is lost or repeated.
// Reset: rst (synchronous) clears the timer, counters, long-press flag and the
//   valid bits of both pipeline registers; loads register defaults 50/2/15/4.
module button_click_gesture_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcg_pkg::TICK_W-1:0]    cfg_wdata,
  bcg_in_if.sink                        button,
  bcg_out_if.source                     result
);

  bcg_pkg::cfg_t    cfg;
  bcg_pkg::result_t res;

  logic stage_valid;
  logic stage_pressed;
  logic out_free;
  logic advance;

  assign out_free     = !result.valid || result.ready;
  assign advance      = stage_valid && out_free;
  assign button.ready = !stage_valid || advance;

  bcg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcg_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .pressed (stage_pressed),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (button.ready) begin
        stage_valid <= button.valid;
      end
      if (out_free) begin
        result.valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (button.valid && button.ready) begin
      stage_pressed <= button.pressed;
    end
    if (advance) begin
      result.click_result   <= res.click_result;
      result.long_active    <= res.long_active;
      result.result_written <= res.result_written;
    end
  end

endmodule

// ===== design/bcg_cfg.sv =====
`timescale 1ns / 1ps

module bcg_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcg_pkg::TICK_W-1:0]    cfg_wdata,
  output bcg_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks      <= bcg_pkg::LONG_PRESS_RST;
      cfg.short_press_ticks     <= bcg_pkg::SHORT_PRESS_RST;
      cfg.release_timeout_ticks <= bcg_pkg::RELEASE_TMO_RST;
      cfg.max_clicks            <= bcg_pkg::MAX_CLICKS_RST;
    end else if (cfg_we) begin
      unique case (bcg_pkg::cfg_index_t'(cfg_index))
        bcg_pkg::CFG_LONG_PRESS:  cfg.long_press_ticks      <= cfg_wdata;
        bcg_pkg::CFG_SHORT_PRESS: cfg.short_press_ticks     <= cfg_wdata;
        bcg_pkg::CFG_RELEASE_TMO: cfg.release_timeout_ticks <= cfg_wdata;
        bcg_pkg::CFG_MAX_CLICKS:  cfg.max_clicks <= cfg_wdata[bcg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bcg_core.sv =====
`timescale 1ns / 1ps

module bcg_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             pressed,
  input  bcg_pkg::cfg_t    cfg,
  output bcg_pkg::result_t res
);

  logic signed [bcg_pkg::TIMER_W-1:0] press_timer, press_timer_next;
  logic [bcg_pkg::COUNT_W-1:0]        click_counter, click_counter_next;
  logic [bcg_pkg::COUNT_W-1:0]        result_clicks, result_clicks_next;
  logic                               long_flag, long_flag_next;
  logic                               written;

  logic signed [bcg_pkg::TIMER_W-1:0] long_th, short_th, tmo_th, timer_up;
  logic [bcg_pkg::COUNT_W-1:0]        count_inc;

  assign long_th  = $signed({1'b0, cfg.long_press_ticks});
  assign short_th = $signed({1'b0, cfg.short_press_ticks});
  assign tmo_th   = 8'sd0 - $signed({1'b0, cfg.release_timeout_ticks});
  assign timer_up = (press_timer < bcg_pkg::TIMER_MAX) ? press_timer + 8'sd1 : press_timer;
  assign count_inc = click_counter + 4'd1;

  always_comb begin
    press_timer_next   = press_timer;
    click_counter_next = click_counter;
    result_clicks_next = result_clicks;
    long_flag_next     = long_flag;
    written            = 1'b0;
    priority if (pressed) begin
      if (!long_flag) begin
        press_timer_next = timer_up;
        if (timer_up >= long_th) begin
          long_flag_next     = 1'b1;
          result_clicks_next = '0;
          written            = 1'b1;
        end
      end
    end else if (press_timer >= short_th) begin
      press_timer_next = '0;
      if (long_flag) begin
        long_flag_next     = 1'b0;
        result_clicks_next = '0;
        written            = 1'b1;
      end else if (count_inc == cfg.max_clicks) begin
        result_clicks_next = count_inc;
        click_counter_next = '0;
        written            = 1'b1;
      end else begin
        click_counter_next = count_inc;
      end
    end else if (click_counter != '0 && press_timer > tmo_th) begin
      press_timer_next = press_timer - 8'sd1;
    end else if (click_counter != '0) begin
      result_clicks_next = click_counter;
      click_counter_next = '0;
      written            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_timer   <= '0;
      click_counter <= '0;
      result_clicks <= '0;
      long_flag     <= 1'b0;
    end else if (step) begin
      press_timer   <= press_timer_next;
      click_counter <= click_counter_next;
      result_clicks <= result_clicks_next;
      long_flag     <= long_flag_next;
    end
  end

  assign res.click_result   = result_clicks_next;
  assign res.long_active    = long_flag_next;
  assign res.result_written = written;

endmodule
